// ----- rtl/twwf_pkg.sv -----
// ----------------------------------------------------------------------------
// twwf_pkg
// Shared constants and types for the trimmed weighted window filter.
// ----------------------------------------------------------------------------
package twwf_pkg;

  localparam int CHANNELS        = 3;
  localparam int WINDOW          = 8;
  localparam int IDX_W           = $clog2(WINDOW);
  localparam int KEPT            = WINDOW - 2;
  localparam int WEIGHT_W        = 16;
  localparam int FRAC_BITS       = 16;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_IDX_W       = 3;

  typedef logic [WEIGHT_W-1:0] weight_t;

  localparam weight_t WEIGHT_RESET = 16'd10923;

  // register map: weight_zero .. weight_five sit at 0 .. 5
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST = 3'd5;

endpackage

// ----- rtl/twwf_if.sv -----
// ----------------------------------------------------------------------------
// twwf_in_if / twwf_out_if
// Valid/ready channels carrying one sample or one result per channel.
// ----------------------------------------------------------------------------
interface twwf_in_if #(
  parameter int SAMPLE_BITS = twwf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] roll_sample;
  logic signed [SAMPLE_BITS-1:0] pitch_sample;
  logic signed [SAMPLE_BITS-1:0] thrust_sample;

  modport source (output valid, roll_sample, pitch_sample, thrust_sample, input ready);
  modport sink   (input valid, roll_sample, pitch_sample, thrust_sample, output ready);
endinterface

interface twwf_out_if #(
  parameter int SAMPLE_BITS = twwf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] roll_out;
  logic signed [SAMPLE_BITS-1:0] pitch_out;
  logic signed [SAMPLE_BITS-1:0] thrust_out;

  modport source (output valid, roll_out, pitch_out, thrust_out, input ready);
  modport sink   (input valid, roll_out, pitch_out, thrust_out, output ready);
endinterface

// ----- rtl/trimmed_weighted_window_filter.sv -----
// ----------------------------------------------------------------------------
// trimmed_weighted_window_filter
// Per-channel 8-sample window; drops min and max, weighted sum of the rest.
//
//   port     dir   beat content
//   in_ch    sink  roll/pitch/thrust sample, signed Q15.16
//   out_ch   src   roll/pitch/thrust filtered value, saturated
//   cfg_*    in    weight register write, index 0..5, Q0.16
//
// While the window fills, a beat is stored and yields no result.
// Once full, a beat makes two passes of 8 reads over the window memory
// (min/max scan, then weighted sum), then pipeline drain and write-back.
// The result waits in the output register; the next beat is accepted meanwhile,
// and only write-back of a following result stalls on out_ch.ready.
// Reset is synchronous; window contents are not cleared, the fill count is.
// ----------------------------------------------------------------------------
module trimmed_weighted_window_filter #(
  parameter int SAMPLE_BITS = twwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  twwf_in_if.sink                          in_ch,
  twwf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [twwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twwf_pkg::WEIGHT_W-1:0]    cfg_data
);
  import twwf_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SHR_W  = ACC_W - FRAC_BITS;
  localparam int ROW_W  = CHANNELS * SAMPLE_BITS;
  localparam logic signed [SHR_W-1:0] SAT_HI =
    SHR_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [SHR_W-1:0] SAT_LO = -SAT_HI - SHR_W'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SUM, ST_FINISH} state_t;

  state_t                        state_r;
  logic [IDX_W-1:0]              cnt_r;
  logic [IDX_W-1:0]              head_r;
  logic [IDX_W:0]                fill_r;
  logic                          out_valid_r;
  logic [ROW_W-1:0]              out_row_r;
  logic [ROW_W-1:0]              fresh_r;

  weight_t                       weight_r [KEPT];
  weight_t                       wq_r     [CHANNELS][KEPT];

  logic [ROW_W-1:0]              win_mem  [WINDOW];
  logic [ROW_W-1:0]              rd_data_r;
  logic                          d_vld_r;
  logic                          d_scan_r;
  logic [IDX_W-1:0]              d_idx_r;

  logic signed [SAMPLE_BITS-1:0] min_r  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] max_r  [CHANNELS];
  logic [IDX_W-1:0]              lo_r   [CHANNELS];
  logic [IDX_W-1:0]              hi_r   [CHANNELS];
  logic signed [PROD_W-1:0]      prod_r [CHANNELS];
  logic [CHANNELS-1:0]           pv_r;
  logic signed [ACC_W-1:0]       acc_r  [CHANNELS];

  logic                          in_acc;
  logic                          full;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          drained;
  logic                          finish_go;
  logic                          mem_we;
  logic [ROW_W-1:0]              mem_wd;
  logic [ROW_W-1:0]              in_row;
  logic [ROW_W-1:0]              res_row;
  logic signed [SAMPLE_BITS-1:0] rd_s   [CHANNELS];
  logic [IDX_W-1:0]              lo_eff [CHANNELS];
  logic [IDX_W-1:0]              hi_eff [CHANNELS];
  logic [CHANNELS-1:0]           keep;
  logic signed [SHR_W-1:0]       shr    [CHANNELS];

  assign in_row    = {in_ch.thrust_sample, in_ch.pitch_sample, in_ch.roll_sample};
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign full      = (fill_r == (IDX_W + 1)'(WINDOW));
  assign rd_en     = (state_r == ST_SCAN) || (state_r == ST_SUM);
  assign rd_addr   = head_r + cnt_r;
  assign drained   = !d_vld_r && (pv_r == '0);
  assign finish_go = (state_r == ST_FINISH) && drained && (!out_valid_r || out_ch.ready);
  assign mem_we    = (in_acc && !full) || finish_go;
  assign mem_wd    = in_acc ? in_row : fresh_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.roll_out   = out_row_r[SAMPLE_BITS-1:0];
  assign out_ch.pitch_out  = out_row_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign out_ch.thrust_out = out_row_r[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rd_s[c]   = rd_data_r[c*SAMPLE_BITS +: SAMPLE_BITS];
      // all-equal window: first two entries are dropped
      lo_eff[c] = (min_r[c] == max_r[c]) ? IDX_W'(0) : lo_r[c];
      hi_eff[c] = (min_r[c] == max_r[c]) ? IDX_W'(1) : hi_r[c];
      keep[c]   = (d_idx_r != lo_eff[c]) && (d_idx_r != hi_eff[c]);
      shr[c]    = SHR_W'(acc_r[c] >>> FRAC_BITS);
      if (shr[c] > SAT_HI) begin
        res_row[c*SAMPLE_BITS +: SAMPLE_BITS] = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shr[c] < SAT_LO) begin
        res_row[c*SAMPLE_BITS +: SAMPLE_BITS] = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        res_row[c*SAMPLE_BITS +: SAMPLE_BITS] = shr[c][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && !finish_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (!full) begin
              head_r <= head_r + IDX_W'(1);
              fill_r <= fill_r + (IDX_W + 1)'(1);
            end else begin
              fresh_r <= in_row;
              cnt_r   <= '0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(WINDOW - 1)) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(WINDOW - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid_r <= 1'b1;
            out_row_r   <= res_row;
            head_r      <= head_r + IDX_W'(1);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEPT; i++) begin
        weight_r[i] <= WEIGHT_RESET;
      end
    end else if (cfg_we && (cfg_index <= REG_WEIGHT_LAST)) begin
      weight_r[cfg_index] <= cfg_data;
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[head_r] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      pv_r    <= '0;
    end else begin
      d_vld_r <= rd_en;
      pv_r    <= (d_vld_r && !d_scan_r) ? keep : '0;
    end
  end

  always_ff @(posedge clk) begin
    d_scan_r <= (state_r == ST_SCAN);
    d_idx_r  <= cnt_r;
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_acc) begin
        acc_r[c] <= '0;
        wq_r[c]  <= weight_r;
      end
      if (d_vld_r && d_scan_r) begin
        if (d_idx_r == '0) begin
          min_r[c] <= rd_s[c];
          max_r[c] <= rd_s[c];
          lo_r[c]  <= '0;
          hi_r[c]  <= '0;
        end else begin
          if (rd_s[c] < min_r[c]) begin
            min_r[c] <= rd_s[c];
            lo_r[c]  <= d_idx_r;
          end
          if (rd_s[c] > max_r[c]) begin
            max_r[c] <= rd_s[c];
            hi_r[c]  <= d_idx_r;
          end
        end
      end
      if (d_vld_r && !d_scan_r && keep[c]) begin
        prod_r[c] <= PROD_W'(rd_s[c]) * PROD_W'($signed({1'b0, wq_r[c][0]}));
        for (int j = 0; j < KEPT - 1; j++) begin
          wq_r[c][j] <= wq_r[c][j+1];
        end
      end
      if (pv_r[c]) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

endmodule

// ----- rtl/twwf_checker.sv -----
// ----------------------------------------------------------------------------
// twwf_checker
// Port-level checks for the trimmed weighted window filter, bound to the top.
// ----------------------------------------------------------------------------
module twwf_checker #(
  parameter int SAMPLE_BITS = twwf_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] roll_out,
  input logic [SAMPLE_BITS-1:0] pitch_out,
  input logic [SAMPLE_BITS-1:0] thrust_out
);
  import twwf_pkg::*;

  logic [IDX_W:0] seen_r;
  logic [1:0]     pend_r;
  logic           in_beat;
  logic           out_beat;
  logic           filled;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign filled   = (seen_r == (IDX_W + 1)'(WINDOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= '0;
    end else begin
      if (in_beat && !filled) begin
        seen_r <= seen_r + (IDX_W + 1)'(1);
      end
      pend_r <= pend_r + 2'((in_beat && filled) ? 1 : 0) - 2'(out_beat ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(roll_out) && $stable(pitch_out) && $stable(thrust_out))
    else $error("result payload changed while stalled");

  a_fill_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> filled)
    else $error("result before window filled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a matching input beat");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two results in flight");

endmodule

bind trimmed_weighted_window_filter twwf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_twwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .roll_out   (out_ch.roll_out),
  .pitch_out  (out_ch.pitch_out),
  .thrust_out (out_ch.thrust_out)
);

// ----- tb/trimmed_weighted_window_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_weighted_window_filter_tb
// Drives sample beats into the filter and checks every result beat.
// The testbench keeps its own copy of the three 8-deep windows and the
// weights. Each accepted beat updates that copy and may queue the trimmed,
// weighted and saturated value expected for roll, pitch and thrust. A
// directed table comes first, then random beats over several weight settings
// and several idle and stall patterns, including one long hold-off on the
// result side.
// ----------------------------------------------------------------------------
module trimmed_weighted_window_filter_tb;
  import twwf_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int NUM_DIR      = 20;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_PHASE   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_FIRST   = 150;
  localparam int RAND_PHASE   = 220;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT        = 5000;
  localparam int NUM_REGS     = 2 ** CFG_IDX_W;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    sample_t roll;
    sample_t pitch;
    sample_t thrust;
  } filt_t;

  typedef struct packed {
    sample_t roll;
    sample_t pitch;
    sample_t thrust;
    logic    typed;
    filt_t   want;
  } dir_row_t;

  typedef struct {
    sample_t roll;
    sample_t pitch;
    sample_t thrust;
    bit      typed;
    filt_t   want;
  } beat_t;

  typedef enum {W_KEEP, W_MAX, W_ZERO, W_RAND} weight_mode_e;
  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};

  // full windows of equal values first, then extremes and bit patterns
  localparam dir_row_t DIR_TBL [NUM_DIR] = '{
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0000, 1'b0, '0},
    '{S_MIN, S_MAX, 32'hFFFF_FFFF, 1'b1, '{S_MAX, S_MIN, 32'h0000_0000}},
    '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b1, '{S_MAX, S_MIN, 32'h0000_0000}},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0001, S_MIN, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, S_MAX, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_8000, 1'b0, '0},
    '{32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, '0},
    '{32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678, 1'b0, '0},
    '{32'hEDCB_A988, 32'h0000_FFFF, 32'hFFFF_0001, 1'b0, '0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{S_MAX, S_MIN, 32'h0000_0001, 1'b0, '0}
  };

  localparam weight_mode_e PHASE_WMODE [NUM_PHASES] =
    '{W_KEEP, W_MAX, W_ZERO, W_RAND, W_RAND, W_RAND, W_RAND, W_RAND};
  localparam idle_mode_e PHASE_IDLE [NUM_PHASES] =
    '{IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]  cfg_data;

  twwf_in_if  #(.SAMPLE_BITS(SB)) in_ch  ();
  twwf_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  trimmed_weighted_window_filter #(.SAMPLE_BITS(SB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  sample_t     win_hist [CHANNELS][WINDOW];
  int unsigned fill_cnt;
  weight_t     weight_reg [KEPT];

  filt_t       filtered_q [$];
  beat_t       stim_q [$];
  int          n_pushed;
  int          n_accepted;
  int          mismatches;
  int          src_idle_pct;
  int          snk_stall_pct;
  bit          hold_req;
  int          hold_left;
  bit          in_taken;
  bit          out_taken;
  bit          cur_typed;
  filt_t       cur_want;
  int          quiet_cycles;
  filt_t       pred;
  filt_t       got;
  filt_t       want;
  beat_t       drv_beat;

  function automatic sample_t trim_sum(input sample_t row [WINDOW]);
    int      lo;
    int      hi;
    int      k;
    longint  acc;
    longint  top;
    longint  bottom;
    lo = 0;
    for (int i = 1; i < WINDOW; i++)
      if (row[i] < row[lo]) lo = i;
    hi = (lo == 0) ? 1 : 0;
    for (int i = 0; i < WINDOW; i++)
      if (i != lo && row[i] > row[hi]) hi = i;
    k   = 0;
    acc = 0;
    for (int i = 0; i < WINDOW; i++) begin
      if (i != lo && i != hi && k < KEPT) begin
        acc += longint'(row[i]) * longint'(weight_reg[k]);
        k++;
      end
    end
    acc    = acc >>> FRAC_BITS;
    top    = (longint'(1) <<< (SB - 1)) - 1;
    bottom = -top - 1;
    if (acc > top) acc = top;
    if (acc < bottom) acc = bottom;
    return sample_t'(acc);
  endfunction

  function automatic bit filter_predict(input sample_t r, input sample_t p, input sample_t t,
                                        output filt_t res);
    sample_t fresh [CHANNELS];
    sample_t row [WINDOW];
    sample_t outv [CHANNELS];
    fresh[0] = r;
    fresh[1] = p;
    fresh[2] = t;
    res      = '0;
    if (fill_cnt < WINDOW) begin
      for (int c = 0; c < CHANNELS; c++) win_hist[c][fill_cnt] = fresh[c];
      fill_cnt++;
      return 1'b0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int i = 0; i < WINDOW; i++) row[i] = win_hist[c][i];
      outv[c] = trim_sum(row);
      for (int i = 0; i < WINDOW - 1; i++) win_hist[c][i] = win_hist[c][i+1];
      win_hist[c][WINDOW-1] = fresh[c];
    end
    res = '{outv[0], outv[1], outv[2]};
    return 1'b1;
  endfunction

  function automatic sample_t rand_sample(input sample_t prev);
    case ($urandom_range(9)) inside
      [0:3]: return sample_t'($urandom);
      4: begin
        case ($urandom_range(3))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      [5:6]:   return sample_t'(int'($urandom_range(1 << 19)) - (1 << 18));
      [7:8]:   return prev;
      default: return prev + sample_t'(int'($urandom_range(64)) - 32);
    endcase
  endfunction

  function automatic void check_field(input string name, input sample_t exp_v,
                                      input sample_t act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  task automatic push_beat(input sample_t r, input sample_t p, input sample_t t,
                           input bit typed, input filt_t exp_v);
    beat_t b;
    b.roll   = r;
    b.pitch  = p;
    b.thrust = t;
    b.typed  = typed;
    b.want   = exp_v;
    stim_q.insert(stim_q.size(), b);
    n_pushed++;
  endtask

  task automatic write_weights(input weight_mode_e mode);
    weight_t d;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (mode)
        W_MAX:   d = '1;
        W_ZERO:  d = '0;
        default: d = ($urandom_range(3) == 0) ? ($urandom_range(1) ? '1 : '0)
                                               : weight_t'($urandom);
      endcase
      if (i > int'(REG_WEIGHT_LAST)) d = weight_t'($urandom);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= d;
      if (i <= int'(REG_WEIGHT_LAST)) weight_reg[i] = d;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (n_accepted != n_pushed || filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // beat monitor and predictor update
  always @(posedge clk) begin
    in_taken  = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (in_taken) begin
      n_accepted++;
      if (filter_predict(in_ch.roll_sample, in_ch.pitch_sample, in_ch.thrust_sample, pred))
        filtered_q.insert(filtered_q.size(), cur_typed ? cur_want : pred);
    end
    if (out_taken) begin
      got = '{out_ch.roll_out, out_ch.pitch_out, out_ch.thrust_out};
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %h %h %h", $realtime,
                   got.roll, got.pitch, got.thrust);
      end else begin
        want = filtered_q.pop_front();
        check_field("roll_out", want.roll, got.roll);
        check_field("pitch_out", want.pitch, got.pitch);
        check_field("thrust_out", want.thrust, got.thrust);
      end
    end
    if (rst_n) begin
      quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, LIMIT);
        $display("trimmed_weighted_window_filter_tb: FAIL");
        $finish;
      end
    end
  end

  // sample sender
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_beat = stim_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.roll_sample   <= drv_beat.roll;
        in_ch.pitch_sample  <= drv_beat.pitch;
        in_ch.thrust_sample <= drv_beat.thrust;
        cur_typed = drv_beat.typed;
        cur_want  = drv_beat.want;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    sample_t prev [CHANNELS];
    int      n_rand;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.roll_sample   = '0;
    in_ch.pitch_sample  = '0;
    in_ch.thrust_sample = '0;
    out_ch.ready        = 1'b0;
    fill_cnt            = 0;
    n_pushed            = 0;
    n_accepted          = 0;
    mismatches          = 0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    hold_req            = 1'b0;
    hold_left           = 0;
    quiet_cycles        = 0;
    in_taken            = 1'b0;
    out_taken           = 1'b0;
    cur_typed           = 1'b0;
    cur_want            = '0;
    for (int k = 0; k < KEPT; k++) weight_reg[k] = WEIGHT_RESET;
    for (int c = 0; c < CHANNELS; c++) prev[c] = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (PHASE_WMODE[ph] != W_KEEP) write_weights(PHASE_WMODE[ph]);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      case (PHASE_IDLE[ph])
        IDLE_SRC:  src_idle_pct = 64;
        IDLE_SNK:  snk_stall_pct = 64;
        IDLE_BOTH: begin
          src_idle_pct  = 28;
          snk_stall_pct = 28;
        end
        default: ;
      endcase
      if (ph == 0)
        foreach (DIR_TBL[i])
          push_beat(DIR_TBL[i].roll, DIR_TBL[i].pitch, DIR_TBL[i].thrust,
                    DIR_TBL[i].typed, DIR_TBL[i].want);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      n_rand = (ph == 0) ? RAND_FIRST : RAND_PHASE;
      for (int n = 0; n < n_rand; n++) begin
        for (int c = 0; c < CHANNELS; c++) prev[c] = rand_sample(prev[c]);
        push_beat(prev[0], prev[1], prev[2], 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("trimmed_weighted_window_filter_tb: PASS");
    end else begin
      $display("trimmed_weighted_window_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
